FILE: hdl/owm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

    localparam int TIMER_BITS = 10;
    localparam int DUR_BITS   = 10;
    localparam int CMP_BITS   = (TIMER_BITS > DUR_BITS) ? TIMER_BITS : DUR_BITS;
    localparam int EXT_BITS   = CMP_BITS + 1;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [EXT_BITS-1:0] TMAX_EXT = EXT_BITS'((1 << TIMER_BITS) - 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SLOT_LOW       = 3'd0,
        REG_SAMPLE_DELAY   = 3'd1,
        REG_SLOT_REST      = 3'd2,
        REG_RESET_LOW      = 3'd3,
        REG_PRESENCE_DELAY = 3'd4,
        REG_RESET_REST     = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        MODE_RESET      = 3'd0,
        MODE_WRITE_BIT  = 3'd1,
        MODE_READ_BIT   = 3'd2,
        MODE_WRITE_BYTE = 3'd3,
        MODE_READ_BYTE  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SLOW  = 3'd1,
        PH_SDLY  = 3'd2,
        PH_SREST = 3'd3,
        PH_RLOW  = 3'd4,
        PH_RWAIT = 3'd5,
        PH_RREST = 3'd6
    } phase_t;

    typedef struct packed {
        logic [3:0] slot_low_us;
        logic [5:0] sample_delay_us;
        logic [6:0] slot_rest_us;
        logic [9:0] reset_low_us;
        logic [7:0] presence_delay_us;
        logic [9:0] reset_rest_us;
    } cfg_t;

    typedef struct packed {
        phase_t                phase;
        logic [TIMER_BITS-1:0] tick_count;
        logic [2:0]            bit_index;
        logic [7:0]            shift_data;
        mode_t                 active_mode;
        logic                  error_flag;
    } state_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic [7:0] result_byte;
        logic       presence_error;
    } res_t;

    // duration saturated at the timer maximum
    function automatic logic [EXT_BITS-1:0] clamp_dur(input logic [DUR_BITS-1:0] dur);
        logic [EXT_BITS-1:0] d;
        d = EXT_BITS'(dur);
        if (d > TMAX_EXT)
            d = TMAX_EXT;
        return d;
    endfunction

    function automatic logic phase_end(input logic [TIMER_BITS-1:0] tick,
                                       input logic [DUR_BITS-1:0] dur);
        logic [EXT_BITS-1:0] t;
        t = EXT_BITS'(tick) + 1'b1;
        return t >= clamp_dur(dur);
    endfunction

    function automatic logic rest_end(input logic [TIMER_BITS-1:0] tick,
                                      input logic [DUR_BITS-1:0] dur);
        return EXT_BITS'(tick) >= clamp_dur(dur);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/one_wire_bus_master.sv
`timescale 1ns / 1ps
`default_nettype none

// one-wire bus master: every request is one microsecond tick of bus time carrying the
// sampled line level and an optional command; the master answers each request with one
// result giving the line drive for that tick, busy, a done pulse, the data byte and the
// presence error. A request is taken every clock cycle except while the output register
// is full and not being taken; its result appears in the next cycle from the output
// register, set by the single registered step of the bus state machine. The user must
// write timing registers through the config port only while the bus is idle; the block
// does not enforce this. Written values take effect on the next command.
module one_wire_bus_master (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [9:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd_valid,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] cmd_byte,
    input  wire logic       line_level,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            drive_low,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      result_byte,
    output logic            presence_error
);

    owm_pkg::cfg_t   cfg_reg;
    owm_pkg::state_t state_reg;
    owm_pkg::state_t state_next;
    owm_pkg::res_t   res_next;
    owm_pkg::res_t   res_reg;
    logic            out_valid_reg;
    logic            accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    owm_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .cmd_valid  (cmd_valid),
        .mode       (mode),
        .cmd_byte   (cmd_byte),
        .line_level (line_level),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_low_us       <= 4'd1;
            cfg_reg.sample_delay_us   <= 6'd15;
            cfg_reg.slot_rest_us      <= 7'd45;
            cfg_reg.reset_low_us      <= 10'd500;
            cfg_reg.presence_delay_us <= 8'd66;
            cfg_reg.reset_rest_us     <= 10'd434;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                owm_pkg::REG_SLOT_LOW:       cfg_reg.slot_low_us       <= cfg_data[3:0];
                owm_pkg::REG_SAMPLE_DELAY:   cfg_reg.sample_delay_us   <= cfg_data[5:0];
                owm_pkg::REG_SLOT_REST:      cfg_reg.slot_rest_us      <= cfg_data[6:0];
                owm_pkg::REG_RESET_LOW:      cfg_reg.reset_low_us      <= cfg_data;
                owm_pkg::REG_PRESENCE_DELAY: cfg_reg.presence_delay_us <= cfg_data[7:0];
                owm_pkg::REG_RESET_REST:     cfg_reg.reset_rest_us     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= owm_pkg::PH_IDLE;
            state_reg.tick_count  <= '0;
            state_reg.bit_index   <= '0;
            state_reg.shift_data  <= '0;
            state_reg.active_mode <= owm_pkg::MODE_RESET;
            state_reg.error_flag  <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign drive_low      = res_reg.drive_low;
    assign busy_res       = res_reg.busy;
    assign done_res       = res_reg.done;
    assign result_byte    = res_reg.result_byte;
    assign presence_error = res_reg.presence_error;

endmodule

`default_nettype wire

FILE: hdl/owm_step.sv
`timescale 1ns / 1ps
`default_nettype none

module owm_step (
    input  wire owm_pkg::cfg_t   cfg,
    input  wire owm_pkg::state_t state,
    input  wire logic            cmd_valid,
    input  wire logic [2:0]      mode,
    input  wire logic [7:0]      cmd_byte,
    input  wire logic            line_level,
    output owm_pkg::state_t      state_next,
    output owm_pkg::res_t        res
);

    owm_pkg::state_t s;
    logic            writing;
    logic            wr_zero;
    logic            bit_val;

    always_comb
    begin
        s = state;
        res = '0;
        bit_val = 1'b0;

        if (s.phase == owm_pkg::PH_IDLE && cmd_valid &&
            mode <= owm_pkg::MODE_READ_BYTE)
        begin
            s.active_mode = owm_pkg::mode_t'(mode);
            s.shift_data  = cmd_byte;
            s.bit_index   = '0;
            s.tick_count  = '0;
            s.error_flag  = 1'b0;
            s.phase = (mode == owm_pkg::MODE_RESET) ? owm_pkg::PH_RLOW : owm_pkg::PH_SLOW;
        end

        writing = (s.active_mode == owm_pkg::MODE_WRITE_BIT) ||
                  (s.active_mode == owm_pkg::MODE_WRITE_BYTE);
        // writing a zero keeps the line low for the whole slot
        wr_zero = writing && !s.shift_data[0];

        case (s.phase)
            owm_pkg::PH_SLOW:
            begin
                res.drive_low = 1'b1;
                if (owm_pkg::phase_end(s.tick_count, owm_pkg::DUR_BITS'(cfg.slot_low_us)))
                begin
                    s.phase = owm_pkg::PH_SDLY;
                    s.tick_count = '0;
                end
                else
                    s.tick_count = s.tick_count + 1'b1;
            end
            owm_pkg::PH_SDLY:
            begin
                res.drive_low = wr_zero;
                if (owm_pkg::phase_end(s.tick_count,
                                       owm_pkg::DUR_BITS'(cfg.sample_delay_us)))
                begin
                    s.phase = owm_pkg::PH_SREST;
                    s.tick_count = '0;
                end
                else
                    s.tick_count = s.tick_count + 1'b1;
            end
            owm_pkg::PH_SREST:
            begin
                res.drive_low = wr_zero;
                if (s.tick_count == '0)
                    s.error_flag = writing ? (s.shift_data[0] & line_level) : line_level;
                if (owm_pkg::rest_end(s.tick_count, owm_pkg::DUR_BITS'(cfg.slot_rest_us)))
                begin
                    bit_val = s.error_flag;
                    s.tick_count = '0;
                    if (s.active_mode == owm_pkg::MODE_WRITE_BIT ||
                        s.active_mode == owm_pkg::MODE_READ_BIT)
                    begin
                        res.done = 1'b1;
                        res.result_byte = {7'd0, bit_val};
                        s.phase = owm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        s.shift_data = {bit_val, s.shift_data[7:1]};
                        if (s.bit_index == 3'd7)
                        begin
                            res.done = 1'b1;
                            res.result_byte = s.shift_data;
                            s.phase = owm_pkg::PH_IDLE;
                        end
                        else
                        begin
                            s.bit_index = s.bit_index + 1'b1;
                            s.phase = owm_pkg::PH_SLOW;
                        end
                    end
                    s.error_flag = 1'b0;
                end
                else
                    s.tick_count = s.tick_count + 1'b1;
            end
            owm_pkg::PH_RLOW:
            begin
                res.drive_low = 1'b1;
                if (owm_pkg::phase_end(s.tick_count, cfg.reset_low_us))
                begin
                    s.phase = owm_pkg::PH_RWAIT;
                    s.tick_count = '0;
                end
                else
                    s.tick_count = s.tick_count + 1'b1;
            end
            owm_pkg::PH_RWAIT:
            begin
                if (owm_pkg::phase_end(s.tick_count,
                                       owm_pkg::DUR_BITS'(cfg.presence_delay_us)))
                begin
                    s.phase = owm_pkg::PH_RREST;
                    s.tick_count = '0;
                end
                else
                    s.tick_count = s.tick_count + 1'b1;
            end
            owm_pkg::PH_RREST:
            begin
                // a high line at the presence sample means no device answered
                if (s.tick_count == '0)
                    s.error_flag = line_level;
                if (owm_pkg::rest_end(s.tick_count, cfg.reset_rest_us))
                begin
                    if (!line_level)
                        s.error_flag = 1'b1;
                    res.done = 1'b1;
                    res.presence_error = s.error_flag;
                    s.phase = owm_pkg::PH_IDLE;
                    s.tick_count = '0;
                end
                else
                    s.tick_count = s.tick_count + 1'b1;
            end
            owm_pkg::PH_IDLE:
            begin
            end
            default:
                s.phase = owm_pkg::PH_IDLE;
        endcase

        res.busy = (s.phase != owm_pkg::PH_IDLE);
        state_next = s;
    end

endmodule

`default_nettype wire

FILE: hdl/owm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module owm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic [7:0] result_byte,
    input wire logic       presence_error
);

    // a completed operation leaves the master idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done with busy still set");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && presence_error |-> done_res)
        else $error("presence error without completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> result_byte == 8'd0)
        else $error("result byte set without completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_byte) && $stable(done_res))
        else $error("stalled result changed");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .result_byte    (result_byte),
    .presence_error (presence_error)
);

`default_nettype wire

FILE: dv/one_wire_bus_master_chk.sv
`timescale 1ns / 1ps

module one_wire_bus_master_chk (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       cmd_valid,
    input  logic [2:0] mode,
    input  logic [7:0] cmd_byte,
    input  logic       line_level,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       drive_low,
    input  logic       busy_res,
    input  logic       done_res,
    input  logic [7:0] result_byte,
    input  logic       presence_error,
    output logic       bus_idle,
    output int         pending,
    output int         fail_count
);

    localparam int TICK_MAX = (1 << owm_pkg::TIMER_BITS) - 1;

    owm_pkg::cfg_t   timing;
    owm_pkg::phase_t ph;
    int              tick;
    logic [2:0]      bit_no;
    logic [7:0]      shreg;
    owm_pkg::mode_t  op;
    logic            sampled;
    owm_pkg::res_t   tick_results[$];
    int              seen;

    function automatic int sat_dur(input int d);
        return (d > TICK_MAX) ? TICK_MAX : d;
    endfunction

    // timed phase ends on this tick
    function automatic logic span_done(input int dur);
        return (tick + 1) >= sat_dur(dur);
    endfunction

    function automatic void step_timer();
        tick = (tick + 1) & TICK_MAX;
    endfunction

    // one microsecond of bus time: advances the master and returns what it shows
    function automatic owm_pkg::res_t bus_tick(input logic cv, input logic [2:0] md,
                                               input logic [7:0] cb, input logic lvl);
        owm_pkg::res_t r;
        logic wr;
        logic b;
        r = '0;
        if (ph == owm_pkg::PH_IDLE && cv && md <= 3'(owm_pkg::MODE_READ_BYTE))
        begin
            op      = owm_pkg::mode_t'(md);
            shreg   = cb;
            bit_no  = '0;
            tick    = 0;
            sampled = 1'b0;
            ph      = (op == owm_pkg::MODE_RESET) ? owm_pkg::PH_RLOW : owm_pkg::PH_SLOW;
        end
        wr = (op == owm_pkg::MODE_WRITE_BIT || op == owm_pkg::MODE_WRITE_BYTE);
        case (ph)
            owm_pkg::PH_SLOW:
            begin
                r.drive_low = 1'b1;
                if (span_done(int'(timing.slot_low_us)))
                begin
                    ph   = owm_pkg::PH_SDLY;
                    tick = 0;
                end
                else
                    step_timer();
            end
            owm_pkg::PH_SDLY:
            begin
                r.drive_low = wr && !shreg[0];
                if (span_done(int'(timing.sample_delay_us)))
                begin
                    ph   = owm_pkg::PH_SREST;
                    tick = 0;
                end
                else
                    step_timer();
            end
            owm_pkg::PH_SREST:
            begin
                r.drive_low = wr && !shreg[0];
                if (tick == 0)
                    sampled = wr ? (shreg[0] & lvl) : lvl;
                if (tick >= sat_dur(int'(timing.slot_rest_us)))
                begin
                    b    = sampled;
                    tick = 0;
                    if (op == owm_pkg::MODE_WRITE_BIT || op == owm_pkg::MODE_READ_BIT)
                    begin
                        r.done        = 1'b1;
                        r.result_byte = {7'd0, b};
                        ph            = owm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        // lsb first, so each new bit enters at the top
                        shreg = {b, shreg[7:1]};
                        if (bit_no == 3'd7)
                        begin
                            r.done        = 1'b1;
                            r.result_byte = shreg;
                            ph            = owm_pkg::PH_IDLE;
                        end
                        else
                        begin
                            bit_no = bit_no + 3'd1;
                            ph     = owm_pkg::PH_SLOW;
                        end
                    end
                    sampled = 1'b0;
                end
                else
                    step_timer();
            end
            owm_pkg::PH_RLOW:
            begin
                r.drive_low = 1'b1;
                if (span_done(int'(timing.reset_low_us)))
                begin
                    ph   = owm_pkg::PH_RWAIT;
                    tick = 0;
                end
                else
                    step_timer();
            end
            owm_pkg::PH_RWAIT:
            begin
                if (span_done(int'(timing.presence_delay_us)))
                begin
                    ph   = owm_pkg::PH_RREST;
                    tick = 0;
                end
                else
                    step_timer();
            end
            owm_pkg::PH_RREST:
            begin
                // high at the presence sample means nobody answered
                if (tick == 0)
                    sampled = lvl;
                if (tick >= sat_dur(int'(timing.reset_rest_us)))
                begin
                    if (!lvl)
                        sampled = 1'b1;
                    r.done           = 1'b1;
                    r.presence_error = sampled;
                    ph               = owm_pkg::PH_IDLE;
                    tick             = 0;
                end
                else
                    step_timer();
            end
            default:
                ph = owm_pkg::PH_IDLE;
        endcase
        r.busy = (ph != owm_pkg::PH_IDLE);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("mismatch on result %0d: %s is %h, expected %h", seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        owm_pkg::res_t want;
        if (!rst_n)
        begin
            timing     = '{slot_low_us: 4'd1, sample_delay_us: 6'd15, slot_rest_us: 7'd45,
                           reset_low_us: 10'd500, presence_delay_us: 8'd66,
                           reset_rest_us: 10'd434};
            ph         = owm_pkg::PH_IDLE;
            tick       = 0;
            bit_no     = '0;
            shreg      = '0;
            op         = owm_pkg::MODE_RESET;
            sampled    = 1'b0;
            seen       = 0;
            fail_count = 0;
            tick_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tick_results.size() == 0)
                    flag_mismatch("unexpected result", 8'd0, 8'd0);
                else
                begin
                    want = tick_results.pop_front();
                    if (drive_low !== want.drive_low)
                        flag_mismatch("drive_low", 8'(drive_low), 8'(want.drive_low));
                    if (busy_res !== want.busy)
                        flag_mismatch("busy_res", 8'(busy_res), 8'(want.busy));
                    if (done_res !== want.done)
                        flag_mismatch("done_res", 8'(done_res), 8'(want.done));
                    if (result_byte !== want.result_byte)
                        flag_mismatch("result_byte", result_byte, want.result_byte);
                    if (presence_error !== want.presence_error)
                        flag_mismatch("presence_error", 8'(presence_error),
                                      8'(want.presence_error));
                end
                seen++;
            end
            if (cfg_we)
            begin
                case (owm_pkg::reg_index_t'(cfg_index))
                    owm_pkg::REG_SLOT_LOW:       timing.slot_low_us       = cfg_data[3:0];
                    owm_pkg::REG_SAMPLE_DELAY:   timing.sample_delay_us   = cfg_data[5:0];
                    owm_pkg::REG_SLOT_REST:      timing.slot_rest_us      = cfg_data[6:0];
                    owm_pkg::REG_RESET_LOW:      timing.reset_low_us      = cfg_data[9:0];
                    owm_pkg::REG_PRESENCE_DELAY: timing.presence_delay_us = cfg_data[7:0];
                    owm_pkg::REG_RESET_REST:     timing.reset_rest_us     = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                tick_results.push_back(bus_tick(cmd_valid, mode, cmd_byte, line_level));
        end
        bus_idle = (ph == owm_pkg::PH_IDLE);
        pending  = tick_results.size();
    end

endmodule

FILE: dv/one_wire_bus_master_tb.sv
`timescale 1ns / 1ps

module one_wire_bus_master_tb;

    typedef enum int {
        LINE_NOISE,
        LINE_HIGH,
        LINE_LOW
    } line_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [2:0] cfg_index  = '0;
    logic [9:0] cfg_data   = '0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic       cmd_valid  = 1'b0;
    logic [2:0] mode       = '0;
    logic [7:0] cmd_byte   = '0;
    logic       line_level = 1'b1;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] result_byte;
    logic       presence_error;
    logic       bus_idle;
    int         pending;
    int         fail_count;
    logic       calm       = 1'b0;
    line_t      line_mode  = LINE_NOISE;

    one_wire_bus_master DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd_valid      (cmd_valid),
        .mode           (mode),
        .cmd_byte       (cmd_byte),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .result_byte    (result_byte),
        .presence_error (presence_error)
    );

    one_wire_bus_master_chk CHK (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd_valid      (cmd_valid),
        .mode           (mode),
        .cmd_byte       (cmd_byte),
        .line_level     (line_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .result_byte    (result_byte),
        .presence_error (presence_error),
        .bus_idle       (bus_idle),
        .pending        (pending),
        .fail_count     (fail_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 20);

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic put_tick(input logic cv, input logic [2:0] md, input logic [7:0] cb);
        int gap;
        gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(3, 1) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        cmd_valid = cv;
        mode      = md;
        cmd_byte  = cb;
        case (line_mode)
            LINE_HIGH: line_level = 1'b1;
            LINE_LOW:  line_level = 1'b0;
            default:   line_level = 1'($urandom_range(1));
        endcase
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // keep ticking until the running operation is over; commands here are ignored
    task automatic finish_op();
        while (!bus_idle)
            put_tick($urandom_range(99) < 10, 3'($urandom_range(7)), 8'($urandom_range(255)));
    endtask

    task automatic run_cmd(input owm_pkg::mode_t md, input logic [7:0] cb, input line_t lm);
        line_mode = lm;
        put_tick(1'b1, md, cb);
        finish_op();
    endtask

    task automatic settle();
        finish_op();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input owm_pkg::reg_index_t idx, input logic [9:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // optionally fill the bits above the register width with junk
    function automatic logic [9:0] pad(input int v, input int w, input bit junk);
        logic [9:0] hi;
        hi = junk ? 10'($urandom_range(1023)) : 10'd0;
        return (hi & ~((10'd1 << w) - 10'd1)) | 10'(v);
    endfunction

    task automatic set_timing(input int sl, input int sd, input int sr, input int rl,
                              input int pd, input int rr, input bit junk);
        write_reg(owm_pkg::REG_SLOT_LOW,       pad(sl, 4, junk));
        write_reg(owm_pkg::REG_SAMPLE_DELAY,   pad(sd, 6, junk));
        write_reg(owm_pkg::REG_SLOT_REST,      pad(sr, 7, junk));
        write_reg(owm_pkg::REG_RESET_LOW,      pad(rl, 10, junk));
        write_reg(owm_pkg::REG_PRESENCE_DELAY, pad(pd, 8, junk));
        write_reg(owm_pkg::REG_RESET_REST,     pad(rr, 10, junk));
    endtask

    task automatic random_run(input int n);
        logic [2:0] md;
        for (int k = 0; k < n; k++)
        begin
            if (bus_idle && $urandom_range(99) < 60)
            begin
                case ($urandom_range(9))
                    0:       line_mode = LINE_HIGH;
                    1:       line_mode = LINE_LOW;
                    default: line_mode = LINE_NOISE;
                endcase
                md = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                              : 3'($urandom_range(4));
                put_tick(1'b1, md, 8'($urandom_range(255)));
            end
            else
                put_tick(!bus_idle && $urandom_range(99) < 15, 3'($urandom_range(7)),
                         8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // short timings so the directed part stays brief
        set_timing(1, 2, 3, 4, 2, 3, 1'b0);
        run_cmd(owm_pkg::MODE_RESET, 8'h00, LINE_NOISE);
        run_cmd(owm_pkg::MODE_RESET, 8'hFF, LINE_LOW);
        run_cmd(owm_pkg::MODE_RESET, 8'h00, LINE_HIGH);
        // device answers: low through the presence sample, released by the final check
        line_mode = LINE_LOW;
        put_tick(1'b1, owm_pkg::MODE_RESET, 8'h00);
        repeat (8) put_tick(1'b0, owm_pkg::MODE_RESET, 8'h00);
        line_mode = LINE_HIGH;
        finish_op();
        run_cmd(owm_pkg::MODE_WRITE_BIT, 8'h01, LINE_HIGH);
        run_cmd(owm_pkg::MODE_WRITE_BIT, 8'hFE, LINE_HIGH);
        run_cmd(owm_pkg::MODE_READ_BIT, 8'h00, LINE_HIGH);
        run_cmd(owm_pkg::MODE_READ_BIT, 8'hFF, LINE_LOW);
        run_cmd(owm_pkg::MODE_WRITE_BYTE, 8'h00, LINE_HIGH);
        run_cmd(owm_pkg::MODE_WRITE_BYTE, 8'hFF, LINE_HIGH);
        run_cmd(owm_pkg::MODE_WRITE_BYTE, 8'hA5, LINE_NOISE);
        run_cmd(owm_pkg::MODE_WRITE_BYTE, 8'hFF, LINE_LOW);
        run_cmd(owm_pkg::MODE_READ_BYTE, 8'h5A, LINE_HIGH);
        run_cmd(owm_pkg::MODE_READ_BYTE, 8'h00, LINE_LOW);
        // modes above the last one are dropped
        line_mode = LINE_NOISE;
        put_tick(1'b1, 3'd5, 8'h81);
        put_tick(1'b1, 3'd6, 8'h42);
        put_tick(1'b1, 3'd7, 8'h24);
        // a request while busy must not restart the operation
        put_tick(1'b1, owm_pkg::MODE_READ_BYTE, 8'h3C);
        put_tick(1'b1, owm_pkg::MODE_RESET, 8'hC3);
        finish_op();

        settle();
        set_timing(1, 15, 45, 500, 66, 434, 1'b0);
        random_run(100);

        settle();
        set_timing(0, 0, 0, 0, 0, 0, 1'b0);
        run_cmd(owm_pkg::MODE_WRITE_BYTE, 8'h96, LINE_NOISE);
        random_run(100);

        settle();
        set_timing(1, 1, 1, 1, 1, 1, 1'b0);
        random_run(100);

        settle();
        set_timing(15, 63, 127, 1023, 255, 1023, 1'b0);
        random_run(150);

        settle();
        set_timing($urandom_range(4), $urandom_range(4), $urandom_range(4),
                   $urandom_range(6), $urandom_range(6), $urandom_range(6), 1'b1);
        random_run(250);

        settle();
        set_timing($urandom_range(4), $urandom_range(4), $urandom_range(4),
                   $urandom_range(6), $urandom_range(6), $urandom_range(6), 1'b0);
        calm = 1'b1;
        random_run(250);
        calm = 1'b0;

        settle();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
